[src/frame_tagged_history_ring_top_defines.svh]
// Assertion macros for the frame-tagged history ring.
// Taken in by the port checker; no other dependencies.
`ifndef FRAME_TAGGED_HISTORY_RING_TOP_DEFINES_SVH
`define FRAME_TAGGED_HISTORY_RING_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define FTR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the same cycle
`define FTR_ASSERT_IMPL(label, ante, cons, msg) \
  `FTR_ASSERT(label, (ante) |-> (cons), msg)

// Implication checked in the next cycle
`define FTR_ASSERT_NEXT(label, ante, cons, msg) \
  `FTR_ASSERT(label, (ante) |=> (cons), msg)

`endif

[src/ftr_pkg.sv]
// Package for the frame-tagged history ring: sizes, request and status codes,
// controller state type. No dependencies.
package ftr_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int TAG_W = 32;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_CREATE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_CREATED = 2'd1,
    ST_NONE    = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_PAST,
    S_ADV,
    S_RESP
  } state_t;

endpackage

[src/frame_tagged_history_ring_top.sv]
// Frame-tagged history ring: tag memory with per-slot valid bits, head pointer
// and request sequencer. Depends on ftr_pkg.
//
//  channel | dir | tdata                          | tuser
//  in_     | in  | frame_id[31:0]                 | op[1:0]
//  out_    | out | slot_index[6:0], head_slot[13:7] | status[1:0]
//
// Acceptance to output register: clear or unused op via S_RESP; head frame, far jump,
// out-of-range or future get via S_HEAD, S_RESP; past frame via S_HEAD, S_PAST, S_RESP;
// forward create of n frames (n < DEPTH) via S_HEAD, S_ADV (one slot freed per cycle), S_RESP.
// Clear drops all valid bits, a far create jump all but its new slot; no clearing pass after reset.
// One request in flight; a new one is taken once the previous result sits in the
// output register, which holds it until out_tready.
module frame_tagged_history_ring_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ftr_pkg::TAG_W-1:0] in_tdata,   // frame_id
  input  logic [1:0]                in_tuser,   // op
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // slot_index, head_slot, pad
  output logic [1:0]                out_tuser   // status
);
  import ftr_pkg::*;

  logic [TAG_W-1:0] tag_mem [DEPTH];

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [TAG_W-1:0] fid_r, fid_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [TAG_W-1:0] rd_data_r;
  logic             rd_vld_r;
  status_t          res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_slot_r, res_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [IDX_W-1:0] out_head_r, out_head_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  logic             in_acc;
  logic             out_free;
  logic [TAG_W-1:0] cur_tag;
  logic             hit_head;
  logic             is_past;
  logic [TAG_W-1:0] back_off;
  logic [TAG_W-1:0] fwd_off;
  logic             back_near;
  logic             fwd_near;
  logic [IDX_W:0]   past_wide;
  logic [IDX_W-1:0] past_ptr;
  logic [IDX_W-1:0] adv_ptr;
  logic             adv_last;
  logic             is_create;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cur_tag   = rd_vld_r ? rd_data_r : '0;
  assign hit_head  = (fid_r == cur_tag);
  assign is_past   = (fid_r < cur_tag);
  assign back_off  = cur_tag - fid_r;
  assign fwd_off   = fid_r - cur_tag;
  assign back_near = (back_off < TAG_W'(DEPTH));
  assign fwd_near  = (fwd_off < TAG_W'(DEPTH));
  assign past_wide = ({1'b0, back_off[IDX_W-1:0]} <= {1'b0, head_r}) ?
                     ({1'b0, head_r} - {1'b0, back_off[IDX_W-1:0]}) :
                     ((IDX_W+1)'(DEPTH) - ({1'b0, back_off[IDX_W-1:0]} - {1'b0, head_r}));
  assign past_ptr  = past_wide[IDX_W-1:0];
  assign adv_ptr   = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
  assign adv_last  = (cnt_r == IDX_W'(1));
  assign is_create = (op_r == OP_CREATE);

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_head_r, out_slot_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_GET || in_tuser == OP_CREATE) state_nxt = S_HEAD;
          else state_nxt = S_RESP;
        end
      end
      S_HEAD: begin
        if (hit_head) state_nxt = S_RESP;
        else if (is_past) state_nxt = back_near ? S_PAST : S_RESP;
        else if (is_create && fwd_near) state_nxt = S_ADV;
        else state_nxt = S_RESP;
      end
      S_PAST: state_nxt = S_RESP;
      S_ADV: begin
        if (adv_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = 1'b0;
    head_nxt       = head_r;
    op_nxt         = op_r;
    fid_nxt        = fid_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_head_nxt   = out_head_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_raddr      = head_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          op_nxt         = in_tuser;
          fid_nxt        = in_tdata;
          res_status_nxt = ST_NONE;
          res_slot_nxt   = '0;
          if (in_tuser == OP_CLEAR) begin
            valid_nxt      = '0;
            head_nxt       = '0;
            res_status_nxt = ST_CLEARED;
          end
        end
      end
      S_HEAD: begin
        if (hit_head) begin
          res_status_nxt = ST_FOUND;
          res_slot_nxt   = head_r;
        end else if (is_past) begin
          ptr_nxt   = past_ptr;
          mem_raddr = past_ptr;
        end else if (is_create) begin
          if (fwd_near) begin
            cnt_nxt = fwd_off[IDX_W-1:0];
          end else begin
            valid_nxt              = '0;
            valid_nxt[DEPTH-1]     = 1'b1;
            head_nxt               = IDX_W'(DEPTH - 1);
            mem_we                 = 1'b1;
            mem_waddr              = IDX_W'(DEPTH - 1);
            res_status_nxt         = ST_CREATED;
            res_slot_nxt           = IDX_W'(DEPTH - 1);
          end
        end
      end
      S_PAST: begin
        mem_waddr = ptr_r;
        if (is_create && cur_tag == '0) begin
          mem_we           = 1'b1;
          valid_nxt[ptr_r] = 1'b1;
          res_status_nxt   = ST_CREATED;
          res_slot_nxt     = ptr_r;
        end else if (cur_tag == fid_r) begin
          res_status_nxt = ST_FOUND;
          res_slot_nxt   = ptr_r;
        end
      end
      S_ADV: begin
        head_nxt  = adv_ptr;
        cnt_nxt   = cnt_r - IDX_W'(1);
        mem_waddr = adv_ptr;
        if (adv_last) begin
          mem_we             = 1'b1;
          valid_nxt[adv_ptr] = 1'b1;
          res_status_nxt     = ST_CREATED;
          res_slot_nxt       = adv_ptr;
        end else begin
          valid_nxt[adv_ptr] = 1'b0;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_head_nxt   = head_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= fid_r;
    end
    rd_data_r <= tag_mem[mem_raddr];
    rd_vld_r  <= valid_nxt[mem_raddr] & valid_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    fid_r        <= fid_nxt;
    ptr_r        <= ptr_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_head_r   <= out_head_nxt;
  end

endmodule

[src/ftr_checker.sv]
// Port-level checker for the frame-tagged history ring, bound to the top level.
// Depends on ftr_pkg and frame_tagged_history_ring_top_defines.svh.
`include "frame_tagged_history_ring_top_defines.svh"

module ftr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [ftr_pkg::TAG_W-1:0] in_tdata,
  input logic [1:0]                in_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [15:0]               out_tdata,
  input logic [1:0]                out_tuser
);
  import ftr_pkg::*;

  `FTR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `FTR_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "request taken while one is in flight")
  `FTR_ASSERT_IMPL(a_cleared_zero, out_tvalid && out_tuser == ST_CLEARED, out_tdata == 16'd0, "clear result not zero")
  `FTR_ASSERT_IMPL(a_none_slot_zero, out_tvalid && out_tuser == ST_NONE, out_tdata[IDX_W-1:0] == '0, "unavailable result carries a slot")

endmodule

bind frame_tagged_history_ring_top ftr_checker u_ftr_checker (.*);
